FILE: design/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with explicit clock and active-low reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the block's default clock and reset.
`define ASSERT_DEF(label, prop, msg) \
  `ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

FILE: design/pld_pkg.sv
// Types, constants and microcode table of the posting list delta encoder.
package pld_pkg;

  localparam int unsigned ValW       = 32;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned GrpW       = 7;
  localparam int unsigned InDataW    = 64;
  localparam int unsigned OutDataW   = 168;
  localparam int unsigned ApbAddrW   = 3;
  localparam int unsigned ApbDataW   = 32;
  localparam int unsigned StepW      = 5;
  localparam int unsigned UcodeDepth = 1 << StepW;

  localparam logic RegWordLevel = 1'b0;  // register index, paddr[2]
  localparam logic WordLevelRst = 1'b1;

  typedef logic [StepW-1:0] step_t;
  typedef logic [ValW-1:0]  val_t;

  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_FLUSH = 2'd1,
    FUNC_RESET = 2'd2,
    FUNC_SNAP  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STREAM_DOC  = 2'd0,
    STREAM_POS  = 2'd1,
    STREAM_STAT = 2'd2,
    STREAM_RSVD = 2'd3
  } stream_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CAPTURE,
    OP_LATCH_NEW,
    OP_LATCH_SAME,
    OP_LATCH_FREQ,
    OP_CLOSE,
    OP_NEW_DOC,
    OP_CLEAR,
    OP_LOAD_FREQ,
    OP_LOAD_DOC,
    OP_LOAD_POS,
    OP_EMIT,
    OP_STAT
  } op_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_FUNC_ADD,
    C_FUNC_FLUSH,
    C_FUNC_RESET,
    C_SAME_DOC,
    C_NOT_WORD,
    C_NO_OPEN,
    C_FV_ZERO,
    C_NOT_MORE
  } cond_e;

  typedef enum logic [1:0] {
    L_NEVER,
    L_ALWAYS,
    L_NO_WORD
  } last_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
    logic  rpt;     // stay on this step while the jump is not taken
    last_e lsel;
  } ctrl_t;

  typedef struct packed {
    op_e   op;
    last_e lsel;
    logic  go;
  } dp_ctrl_t;

  typedef struct packed {
    logic func_add;
    logic func_flush;
    logic func_reset;
    logic same_doc;
    logic not_word;
    logic no_open;
    logic fv_zero;
    logic not_more;
    logic out_free;
  } flags_t;

  // jump targets
  localparam step_t StIdle    = step_t'(0);
  localparam step_t StAdd     = step_t'(5);
  localparam step_t StDocVal  = step_t'(12);
  localparam step_t StDocDone = step_t'(14);
  localparam step_t StSame    = step_t'(17);
  localparam step_t StFlush   = step_t'(21);
  localparam step_t StReset   = step_t'(26);
  localparam step_t StStat    = step_t'(27);

  function automatic ctrl_t uc(op_e op, cond_e cond, step_t target, logic rpt, last_e lsel);
    ctrl_t c;
    c.op     = op;
    c.cond   = cond;
    c.target = target;
    c.rpt    = rpt;
    c.lsel   = lsel;
    return c;
  endfunction

  localparam ctrl_t Ucode [UcodeDepth] = '{
    // dispatch
    uc(OP_CAPTURE,    C_NEVER,      StIdle,    1'b0, L_NEVER),
    uc(OP_NOP,        C_FUNC_ADD,   StAdd,     1'b0, L_NEVER),
    uc(OP_NOP,        C_FUNC_FLUSH, StFlush,   1'b0, L_NEVER),
    uc(OP_NOP,        C_FUNC_RESET, StReset,   1'b0, L_NEVER),
    uc(OP_STAT,       C_ALWAYS,     StIdle,    1'b0, L_ALWAYS),
    // add: new document
    uc(OP_NOP,        C_SAME_DOC,   StSame,    1'b0, L_NEVER),
    uc(OP_LATCH_NEW,  C_NEVER,      StIdle,    1'b0, L_NEVER),
    uc(OP_CLOSE,      C_NEVER,      StIdle,    1'b0, L_NEVER),
    uc(OP_NEW_DOC,    C_NEVER,      StIdle,    1'b0, L_NEVER),
    uc(OP_NOP,        C_FV_ZERO,    StDocVal,  1'b0, L_NEVER),
    uc(OP_LOAD_FREQ,  C_NEVER,      StIdle,    1'b0, L_NEVER),
    uc(OP_EMIT,       C_NOT_MORE,   StDocVal,  1'b1, L_NEVER),
    uc(OP_LOAD_DOC,   C_NEVER,      StIdle,    1'b0, L_NEVER),
    uc(OP_EMIT,       C_NOT_MORE,   StDocDone, 1'b1, L_NO_WORD),
    uc(OP_NOP,        C_NOT_WORD,   StIdle,    1'b0, L_NEVER),
    uc(OP_LOAD_POS,   C_NEVER,      StIdle,    1'b0, L_NEVER),
    uc(OP_EMIT,       C_NOT_MORE,   StIdle,    1'b1, L_ALWAYS),
    // add: same document
    uc(OP_LATCH_SAME, C_NEVER,      StIdle,    1'b0, L_NEVER),
    uc(OP_NOP,        C_NOT_WORD,   StStat,    1'b0, L_NEVER),
    uc(OP_LOAD_POS,   C_NEVER,      StIdle,    1'b0, L_NEVER),
    uc(OP_EMIT,       C_NOT_MORE,   StIdle,    1'b1, L_ALWAYS),
    // flush
    uc(OP_NOP,        C_NO_OPEN,    StStat,    1'b0, L_NEVER),
    uc(OP_LATCH_FREQ, C_NEVER,      StIdle,    1'b0, L_NEVER),
    uc(OP_CLOSE,      C_NEVER,      StIdle,    1'b0, L_NEVER),
    uc(OP_LOAD_FREQ,  C_NEVER,      StIdle,    1'b0, L_NEVER),
    uc(OP_EMIT,       C_NOT_MORE,   StIdle,    1'b1, L_ALWAYS),
    // reset, then statistics-only result
    uc(OP_CLEAR,      C_NEVER,      StIdle,    1'b0, L_NEVER),
    uc(OP_STAT,       C_ALWAYS,     StIdle,    1'b0, L_ALWAYS),
    // unused
    uc(OP_NOP,        C_ALWAYS,     StIdle,    1'b0, L_NEVER),
    uc(OP_NOP,        C_ALWAYS,     StIdle,    1'b0, L_NEVER),
    uc(OP_NOP,        C_ALWAYS,     StIdle,    1'b0, L_NEVER),
    uc(OP_NOP,        C_ALWAYS,     StIdle,    1'b0, L_NEVER)
  };

endpackage

FILE: design/pld_seq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
module pld_seq import pld_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  flags_t   flags_i,
  output logic     in_ready_o,
  output dp_ctrl_t dp_ctrl_o
);

  step_t step_q, step_d;
  ctrl_t ctrl;
  logic  cond_hit;
  logic  stall;

  assign ctrl = Ucode[step_q];

  always_comb begin
    case (ctrl.cond)
      C_NEVER:      cond_hit = 1'b0;
      C_ALWAYS:     cond_hit = 1'b1;
      C_FUNC_ADD:   cond_hit = flags_i.func_add;
      C_FUNC_FLUSH: cond_hit = flags_i.func_flush;
      C_FUNC_RESET: cond_hit = flags_i.func_reset;
      C_SAME_DOC:   cond_hit = flags_i.same_doc;
      C_NOT_WORD:   cond_hit = flags_i.not_word;
      C_NO_OPEN:    cond_hit = flags_i.no_open;
      C_FV_ZERO:    cond_hit = flags_i.fv_zero;
      C_NOT_MORE:   cond_hit = flags_i.not_more;
      default:      cond_hit = 1'b0;
    endcase
  end

  // hold the step while the output register is full or no input is offered
  assign stall = ((ctrl.op == OP_EMIT || ctrl.op == OP_STAT) && !flags_i.out_free) ||
                 (ctrl.op == OP_CAPTURE && !in_valid_i);

  always_comb begin
    if (stall) begin
      step_d = step_q;
    end else if (cond_hit) begin
      step_d = ctrl.target;
    end else if (ctrl.rpt) begin
      step_d = step_q;
    end else begin
      step_d = step_q + step_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StIdle;
    end else begin
      step_q <= step_d;
    end
  end

  assign in_ready_o     = (ctrl.op == OP_CAPTURE);
  assign dp_ctrl_o.op   = ctrl.op;
  assign dp_ctrl_o.lsel = ctrl.lsel;
  assign dp_ctrl_o.go   = !stall;

endmodule

FILE: design/pld_dp.sv
// Datapath: term state, varint shifter and output register.
module pld_dp import pld_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_ctrl_t            dp_ctrl_i,
  input  logic                word_level_i,
  input  logic [1:0]          in_func_i,
  input  val_t                in_doc_i,
  input  val_t                in_pos_i,
  input  logic                out_ready_i,
  output flags_t              flags_o,
  output logic                out_valid_o,
  output logic [OutDataW-1:0] out_data_o,
  output logic [1:0]          out_stream_o,
  output logic                out_last_o
);

  localparam val_t SatMax = '1;

  // captured input (no reset)
  func_e func_q;
  val_t  doc_q, pos_q;

  // term state
  logic seen_q, seen_d;
  val_t prev_doc_q, prev_doc_d;
  val_t prev_pos_q, prev_pos_d;
  val_t open_q, open_d;
  val_t docs_q, docs_d;
  val_t fsum_q, fsum_d;
  val_t fpeak_q, fpeak_d;

  // pending values and shifter (no reset)
  val_t fv_q, dv_q, pv_q, val_q;
  logic pos_flag_q;

  // output register
  logic                out_valid_q;
  stream_e             out_stream_q;
  logic [ByteW-1:0]    out_byte_q;
  logic                out_last_q;
  val_t                o_docs_q, o_fsum_q, o_fpeak_q, o_prev_q, o_open_q;

  logic            act;
  logic            more;
  logic            emit_last;
  logic            out_load;
  logic            out_free;
  logic [ValW:0]   sum_wide;

  assign act      = dp_ctrl_i.go;
  assign more     = (val_q[ValW-1:GrpW] != '0);
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = act && (dp_ctrl_i.op == OP_EMIT || dp_ctrl_i.op == OP_STAT);
  assign sum_wide = {1'b0, fsum_q} + {1'b0, open_q};

  always_comb begin
    case (dp_ctrl_i.lsel)
      L_NEVER:   emit_last = 1'b0;
      L_ALWAYS:  emit_last = !more;
      L_NO_WORD: emit_last = !more && !word_level_i;
      default:   emit_last = 1'b0;
    endcase
  end

  always_comb begin
    seen_d     = seen_q;
    prev_doc_d = prev_doc_q;
    prev_pos_d = prev_pos_q;
    open_d     = open_q;
    docs_d     = docs_q;
    fsum_d     = fsum_q;
    fpeak_d    = fpeak_q;
    if (act) begin
      case (dp_ctrl_i.op)
        OP_LATCH_SAME: begin
          if (open_q != SatMax) open_d = open_q + val_t'(1);
          prev_pos_d = pos_q;
        end
        OP_CLOSE: begin
          fsum_d = sum_wide[ValW] ? SatMax : sum_wide[ValW-1:0];
          if (open_q > fpeak_q) fpeak_d = open_q;
          open_d = '0;
        end
        OP_NEW_DOC: begin
          open_d     = val_t'(1);
          prev_doc_d = doc_q;
          prev_pos_d = pos_q;
          seen_d     = 1'b1;
          if (docs_q != SatMax) docs_d = docs_q + val_t'(1);
        end
        OP_CLEAR: begin
          seen_d     = 1'b0;
          prev_doc_d = '0;
          prev_pos_d = '0;
          open_d     = '0;
          docs_d     = '0;
          fsum_d     = '0;
          fpeak_d    = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= 1'b0;
      prev_doc_q <= '0;
      prev_pos_q <= '0;
      open_q     <= '0;
      docs_q     <= '0;
      fsum_q     <= '0;
      fpeak_q    <= '0;
    end else begin
      seen_q     <= seen_d;
      prev_doc_q <= prev_doc_d;
      prev_pos_q <= prev_pos_d;
      open_q     <= open_d;
      docs_q     <= docs_d;
      fsum_q     <= fsum_d;
      fpeak_q    <= fpeak_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (act) begin
      case (dp_ctrl_i.op)
        OP_CAPTURE: begin
          func_q <= func_e'(in_func_i);
          doc_q  <= in_doc_i;
          pos_q  <= in_pos_i;
        end
        OP_LATCH_NEW: begin
          // first document takes its delta from zero
          dv_q <= doc_q - (seen_q ? prev_doc_q : '0);
          fv_q <= open_q;
          pv_q <= pos_q;
        end
        OP_LATCH_SAME: pv_q <= pos_q - prev_pos_q;
        OP_LATCH_FREQ: fv_q <= open_q;
        OP_LOAD_FREQ: begin
          val_q      <= fv_q;
          pos_flag_q <= 1'b0;
        end
        OP_LOAD_DOC: begin
          val_q      <= dv_q;
          pos_flag_q <= 1'b0;
        end
        OP_LOAD_POS: begin
          val_q      <= pv_q;
          pos_flag_q <= 1'b1;
        end
        OP_EMIT: val_q <= val_q >> GrpW;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (dp_ctrl_i.op == OP_EMIT) begin
        out_stream_q <= pos_flag_q ? STREAM_POS : STREAM_DOC;
        out_byte_q   <= {more, val_q[GrpW-1:0]};
        out_last_q   <= emit_last;
      end else begin
        out_stream_q <= STREAM_STAT;
        out_byte_q   <= '0;
        out_last_q   <= 1'b1;
      end
      o_docs_q  <= docs_q;
      o_fsum_q  <= fsum_q;
      o_fpeak_q <= fpeak_q;
      o_prev_q  <= prev_doc_q;
      o_open_q  <= open_q;
    end
  end

  assign flags_o.func_add   = (func_q == FUNC_ADD);
  assign flags_o.func_flush = (func_q == FUNC_FLUSH);
  assign flags_o.func_reset = (func_q == FUNC_RESET);
  assign flags_o.same_doc   = seen_q && (doc_q == prev_doc_q);
  assign flags_o.not_word   = !word_level_i;
  assign flags_o.no_open    = (open_q == '0);
  assign flags_o.fv_zero    = (fv_q == '0);
  assign flags_o.not_more   = !more;
  assign flags_o.out_free   = out_free;

  assign out_valid_o  = out_valid_q;
  assign out_stream_o = out_stream_q;
  assign out_last_o   = out_last_q;
  assign out_data_o   = {o_open_q, o_prev_q, o_fpeak_q, o_fsum_q, o_docs_q, out_byte_q};

endmodule

FILE: design/posting_list_delta_encoder.sv
// Top level of the posting list delta encoder: streams, register port, sequencer, datapath.
//
//   channel   dir  transfer when             carries
//   s_axis    in   tvalid & tready           func (tuser), doc_id, position (tdata)
//   m_axis    out  tvalid & tready           one varint byte or a statistics-only result
//   apb       in   psel & penable & pwrite   word_level at byte address 0
//
// Dispatch takes 2 to 5 steps; a new document then takes 6 branch and state steps, one
// load step per value and one emit step per output byte from the single shared byte
// shifter. Reset clears all term state and sets word_level; no clearing pass.
// A full output register stalls the step counter; the next item is taken while the
// last result still waits.
module posting_list_delta_encoder import pld_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // doc_id[31:0], position[63:32]
  input  logic [1:0]          s_axis_tuser,   // func[1:0]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // byte_value[7:0], doc_count[39:8], total_freq[71:40], max_freq[103:72],
  // last_doc[135:104], current_freq[167:136]
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic [1:0]          m_axis_tuser,   // stream[1:0]
  output logic                m_axis_tlast,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  logic     word_level_q;
  flags_t   flags;
  dp_ctrl_t dp_ctrl;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_level_q <= WordLevelRst;
    end else if (psel && penable && pwrite && pready && paddr[2] == RegWordLevel) begin
      word_level_q <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == RegWordLevel) ? {{(ApbDataW-1){1'b0}}, word_level_q} : '0;

  pld_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .flags_i    (flags),
    .in_ready_o (s_axis_tready),
    .dp_ctrl_o  (dp_ctrl)
  );

  pld_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .dp_ctrl_i    (dp_ctrl),
    .word_level_i (word_level_q),
    .in_func_i    (s_axis_tuser),
    .in_doc_i     (s_axis_tdata[ValW-1:0]),
    .in_pos_i     (s_axis_tdata[InDataW-1:ValW]),
    .out_ready_i  (m_axis_tready),
    .flags_o      (flags),
    .out_valid_o  (m_axis_tvalid),
    .out_data_o   (m_axis_tdata),
    .out_stream_o (m_axis_tuser),
    .out_last_o   (m_axis_tlast)
  );

endmodule

FILE: design/pld_checker.sv
// Port-level checks of the posting list delta encoder, bound to the top level.
`include "assert_macros.svh"

module pld_checker import pld_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [1:0]          m_axis_tuser,
  input logic                m_axis_tlast
);

  // stalled result keeps its payload
  `ASSERT_DEF(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output payload changed while stalled")

  // statistics-only results are single, closing, zero-byte transfers
  `ASSERT_DEF(a_stat_shape, m_axis_tvalid && m_axis_tuser == STREAM_STAT |-> m_axis_tlast && m_axis_tdata[ByteW-1:0] == '0, "bad statistics-only result")

  // the closing byte of an item never carries a continuation bit
  `ASSERT_DEF(a_last_no_cont, m_axis_tvalid && m_axis_tlast |-> !m_axis_tdata[ByteW-1], "continuation bit on last byte")

  // an open document implies at least one document counted
  `ASSERT_DEF(a_open_has_doc, m_axis_tvalid && m_axis_tdata[167:136] != '0 |-> m_axis_tdata[39:8] != '0, "open frequency without a document")

endmodule

bind posting_list_delta_encoder pld_checker u_checker (.*);

FILE: verif/posting_encoder_checker.sv
// Posting encoder checker: predicts the varint byte stream and statistics, compares results.
`timescale 1ns / 100ps

module posting_encoder_checker import pld_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [InDataW-1:0]  s_tdata_i,   // doc_id[31:0], position[63:32]
  input  logic [1:0]          s_tuser_i,   // func[1:0]
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  // byte_value[7:0], doc_count[39:8], total_freq[71:40], max_freq[103:72],
  // last_doc[135:104], current_freq[167:136]
  input  logic [OutDataW-1:0] m_tdata_i,
  input  logic [1:0]          m_tuser_i,   // stream[1:0]
  input  logic                m_tlast_i,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [ApbAddrW-1:0] paddr_i,
  input  logic [ApbDataW-1:0] pwdata_i,
  input  logic                pready_i,
  output int unsigned         errors_o,
  output int unsigned         pending_o
);

  localparam logic [ApbAddrW-1:0] WordLevelAddr = {RegWordLevel, 2'b00};

  typedef struct packed {
    stream_e         stream;
    logic [ByteW-1:0] byte_value;
    logic            last;
    val_t            doc_count;
    val_t            total_freq;
    val_t            max_freq;
    val_t            last_doc;
    val_t            current_freq;
  } posting_byte_t;

  // term state as the encoder should hold it
  logic        word_level;
  logic        seen_doc;
  val_t        open_doc;
  val_t        prev_pos;
  val_t        open_freq;
  val_t        docs_seen;
  val_t        freq_sum;
  val_t        freq_peak;

  stream_e          item_streams[$];
  logic [ByteW-1:0] item_bytes[$];
  posting_byte_t    expected_bytes[$];
  int unsigned      err_cnt = 0;

  assign errors_o = err_cnt;

  task automatic clear_term();
    seen_doc  = 1'b0;
    open_doc  = '0;
    prev_pos  = '0;
    open_freq = '0;
    docs_seen = '0;
    freq_sum  = '0;
    freq_peak = '0;
  endtask

  // 7-bit groups, low group first, bit 7 set while more groups follow
  task automatic push_varint(val_t v, stream_e s);
    logic [GrpW-1:0] grp;
    do begin
      grp = v[GrpW-1:0];
      v   = v >> GrpW;
      item_bytes.push_back({v != '0, grp});
      item_streams.push_back(s);
    end while (v != '0);
  endtask

  task automatic close_doc();
    logic [ValW:0] sum;
    sum = {1'b0, freq_sum} + {1'b0, open_freq};
    freq_sum = sum[ValW] ? '1 : sum[ValW-1:0];
    if (open_freq > freq_peak) freq_peak = open_freq;
  endtask

  task automatic encode_posting(func_e func, val_t doc, val_t pos);
    val_t          base;
    posting_byte_t r;
    item_bytes.delete();
    item_streams.delete();
    case (func)
      FUNC_ADD: begin
        if (seen_doc && doc == open_doc) begin
          if (word_level) push_varint(pos - prev_pos, STREAM_POS);
          if (open_freq != '1) open_freq++;
          prev_pos = pos;
        end else begin
          base = seen_doc ? open_doc : '0;
          if (open_freq != '0) push_varint(open_freq, STREAM_DOC);
          push_varint(doc - base, STREAM_DOC);
          if (word_level) push_varint(pos, STREAM_POS);
          close_doc();
          open_freq = 1;
          open_doc  = doc;
          prev_pos  = pos;
          seen_doc  = 1'b1;
          if (docs_seen != '1) docs_seen++;
        end
      end
      FUNC_FLUSH: begin
        if (open_freq != '0) begin
          push_varint(open_freq, STREAM_DOC);
          close_doc();
          open_freq = '0;
        end
      end
      FUNC_RESET: clear_term();
      default: ;
    endcase
    if (item_bytes.size() == 0) begin
      item_bytes.push_back('0);
      item_streams.push_back(STREAM_STAT);
    end
    foreach (item_bytes[k]) begin
      r.stream       = item_streams[k];
      r.byte_value   = item_bytes[k];
      r.last         = (k == item_bytes.size() - 1);
      r.doc_count    = docs_seen;
      r.total_freq   = freq_sum;
      r.max_freq     = freq_peak;
      r.last_doc     = open_doc;
      r.current_freq = open_freq;
      expected_bytes.push_back(r);
    end
  endtask

  task automatic check_field(string name, val_t want, val_t got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    posting_byte_t want;
    if (!rst_ni) begin
      word_level = WordLevelRst;
      clear_term();
      expected_bytes.delete();
      pending_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == WordLevelAddr) begin
        word_level = pwdata_i[0];
      end
      if (s_tvalid_i && s_tready_i) begin
        encode_posting(func_e'(s_tuser_i), s_tdata_i[31:0], s_tdata_i[63:32]);
      end
      if (m_tvalid_i && m_tready_i) begin
        if (expected_bytes.size() == 0) begin
          $error("output transfer with no result expected (byte 0x%0h)", m_tdata_i[7:0]);
          err_cnt++;
        end else begin
          want = expected_bytes.pop_front();
          check_field("stream", val_t'(want.stream), val_t'(m_tuser_i));
          check_field("byte_value", val_t'(want.byte_value), val_t'(m_tdata_i[7:0]));
          check_field("last", val_t'(want.last), val_t'(m_tlast_i));
          check_field("doc_count", want.doc_count, m_tdata_i[39:8]);
          check_field("total_freq", want.total_freq, m_tdata_i[71:40]);
          check_field("max_freq", want.max_freq, m_tdata_i[103:72]);
          check_field("last_doc", want.last_doc, m_tdata_i[135:104]);
          check_field("current_freq", want.current_freq, m_tdata_i[167:136]);
        end
      end
      pending_o <= expected_bytes.size();
    end
  end

endmodule

FILE: verif/tb.sv
// Testbench top: clock, reset, stream and register stimulus, verdict.
`timescale 1ns / 100ps

module tb;
  import pld_pkg::*;

  localparam logic [ApbAddrW-1:0] WordLevelAddr = {RegWordLevel, 2'b00};
  localparam int unsigned CycleLimit = 200000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;   // doc_id[31:0], position[63:32]
  logic [1:0]          s_axis_tuser = FUNC_SNAP;  // func[1:0]
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // byte_value[7:0], doc_count[39:8], total_freq[71:40], max_freq[103:72],
  // last_doc[135:104], current_freq[167:136]
  logic [OutDataW-1:0] m_axis_tdata;
  logic [1:0]          m_axis_tuser;        // stream[1:0]
  logic                m_axis_tlast;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ApbAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  int unsigned errors;
  int unsigned pending;
  int unsigned cycles = 0;
  int unsigned stall_left = 0;
  bit          idle_en = 1'b1;
  val_t        cur_doc = '0;
  val_t        cur_pos = '0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  posting_list_delta_encoder u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  posting_encoder_checker u_checker (
    .clk_i, .rst_ni,
    .s_tvalid_i (s_axis_tvalid), .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),  .s_tuser_i  (s_axis_tuser),
    .m_tvalid_i (m_axis_tvalid), .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),  .m_tuser_i  (m_axis_tuser), .m_tlast_i (m_axis_tlast),
    .psel_i (psel), .penable_i (penable), .pwrite_i (pwrite),
    .paddr_i (paddr), .pwdata_i (pwdata), .pready_i (pready),
    .errors_o (errors), .pending_o (pending)
  );

  // receiver back-pressure in random bursts
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= (stall_left == 1);
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left    <= $urandom_range(1, 13);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_item(func_e func, val_t doc, val_t pos);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pos, doc};
    s_axis_tuser  <= func;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_word_level(logic value);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= WordLevelAddr;
    pwdata  <= ApbDataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // mostly well-formed postings: nondecreasing doc ids, rising positions
  task automatic run_postings(int unsigned n);
    int unsigned pick;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        cur_pos = ($urandom_range(0, 9) == 0) ? $urandom() : cur_pos + $urandom_range(0, 300);
        send_item(FUNC_ADD, cur_doc, cur_pos);
      end else if (pick < 75) begin
        cur_doc = cur_doc + (($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(1, 200));
        cur_pos = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 1000);
        send_item(FUNC_ADD, cur_doc, cur_pos);
      end else if (pick < 83) begin
        send_item(FUNC_FLUSH, $urandom(), $urandom());
      end else if (pick < 88) begin
        send_item(FUNC_SNAP, $urandom(), $urandom());
      end else if (pick < 91) begin
        send_item(FUNC_RESET, $urandom(), $urandom());
        cur_doc = '0;
        cur_pos = '0;
      end else begin
        // out-of-order noise
        cur_doc = $urandom();
        cur_pos = $urandom();
        send_item(FUNC_ADD, cur_doc, cur_pos);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // word-level mode from reset
    send_item(FUNC_SNAP, '0, '0);
    send_item(FUNC_FLUSH, '0, '0);             // nothing open
    send_item(FUNC_ADD, '0, '0);               // first doc, id equal to reset value
    send_item(FUNC_ADD, '0, 32'h7F);
    send_item(FUNC_ADD, '0, 32'h80);
    send_item(FUNC_ADD, '0, 32'h5);            // position goes back, delta wraps
    send_item(FUNC_ADD, '1, '1);
    send_item(FUNC_FLUSH, '1, '1);
    send_item(FUNC_ADD, '1, 32'h3);            // reopens the flushed document
    send_item(FUNC_ADD, 32'h10, 32'h1);        // doc id goes back
    send_item(FUNC_SNAP, '1, '1);
    send_item(FUNC_RESET, '0, '0);
    send_item(FUNC_ADD, 32'h1234_5678, 32'h3FFF);
    send_item(FUNC_FLUSH, '0, '0);
    send_item(FUNC_FLUSH, '0, '0);

    // document-level mode
    write_word_level(1'b0);
    send_item(FUNC_ADD, 32'h1234_5679, 32'h9);
    send_item(FUNC_ADD, 32'h1234_5679, 32'hA);  // repeat, no bytes
    send_item(FUNC_ADD, 32'h8000_0000, 32'h0);
    send_item(FUNC_FLUSH, '0, '0);
    send_item(FUNC_SNAP, '0, '0);
    send_item(FUNC_RESET, '1, '1);
    send_item(FUNC_ADD, 32'h4000_0001, '1);

    write_word_level(1'b1);
    run_postings(40);
    write_word_level(1'b0);
    run_postings(20);
    write_word_level(1'b1);
    idle_en = 1'b0;
    run_postings(40);

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/pld_pkg.sv
design/pld_seq.sv
design/pld_dp.sv
design/posting_list_delta_encoder.sv
design/pld_checker.sv
verif/posting_encoder_checker.sv
verif/tb.sv
